FILE: hdl/blp_pkg.sv
// Shared types, widths, defaults and error-unit operation codes for the line rasterizer.
// Depends on nothing; every other file in hdl refers to it by scoped names.
package blp_pkg;

	// Coordinate and error-term widths fixed by the request and result formats.
	localparam int COORD_W = 6;
	localparam int ERR_W = 10;

	// Default grid edge length; coordinates above the grid saturate to its last cell.
	localparam int GRID_SIZE_DEF = 64;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic signed [ERR_W-1:0] err_t;

	// Operations of the shared error-term adder.
	typedef logic [1:0] err_op_t;
	localparam err_op_t OP_INIT = 2'd0;
	localparam err_op_t OP_AXIAL = 2'd1;
	localparam err_op_t OP_DIAG = 2'd2;

	// Line geometry produced by the setup logic, held for the whole run.
	typedef struct packed {
		logic along_y;
		logic minor_neg;
		coord_t maj0;
		coord_t min0;
		coord_t maj_end;
		coord_t dmaj;
		coord_t dmin;
	} setup_t;

endpackage

FILE: hdl/blp_req_if.sv
// Request channel of the line rasterizer: two endpoints with a valid/ready handshake.
// Depends on blp_pkg for the coordinate type.
interface blp_req_if;
	logic valid;
	logic ready;
	blp_pkg::coord_t start_x;
	blp_pkg::coord_t start_y;
	blp_pkg::coord_t end_x;
	blp_pkg::coord_t end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

FILE: hdl/blp_pt_if.sv
// Point channel of the line rasterizer: one grid cell per transfer, last cell marked.
// Depends on blp_pkg for the coordinate type.
interface blp_pt_if;
	logic valid;
	logic ready;
	blp_pkg::coord_t point_x;
	blp_pkg::coord_t point_y;
	logic last_point;

	modport source (output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink (input valid, input point_x, input point_y, input last_point,
		output ready);
endinterface

FILE: hdl/bresenham_line_points_top.sv
// Top level of the Bresenham line rasterizer: sequencer, line state and output register.
// Depends on blp_pkg, blp_req_if, blp_pt_if, blp_setup and blp_err_unit.
//
// Usage:
// A request on req carries two endpoints. Coordinates above GRID_SIZE-1 saturate
// to GRID_SIZE-1. The block answers with every cell of the line on pt, one cell
// per transfer, ordered by increasing major coordinate, last_point high on the
// final cell. A line with equal endpoints gives a single cell.
// req.ready is high only while no line is in progress; a request is taken when
// valid and ready are both high.
// After a request is taken, the endpoints are registered, then the line setup,
// then the initial error, and then the first cell enters the output register.
// Throughput: one cell per cycle while the receiver takes them; the error adder
// forms the initial error once and then updates it after every cell but the last.
// The next request is taken as soon as the last cell of the current line sits in
// the output register, even if the receiver has not yet taken it.
// If the receiver stalls, the held cell stays on pt and the run pauses.
// Reset clears the sequencer and the output register's valid flag: no cell is
// presented and the block is ready for a request.
module bresenham_line_points_top #(
	parameter int GRID_SIZE = blp_pkg::GRID_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	blp_req_if.sink req,
	blp_pt_if.source pt
);

	localparam blp_pkg::coord_t MAX_COORD = blp_pkg::coord_t'(GRID_SIZE - 1);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_INIT = 2'd2;
	localparam logic [1:0] ST_RUN = 2'd3;

	logic [1:0] state_q;
	logic pt_valid_q;
	blp_pkg::coord_t pt_x_q;
	blp_pkg::coord_t pt_y_q;
	logic pt_last_q;

	blp_pkg::coord_t ax_q;
	blp_pkg::coord_t ay_q;
	blp_pkg::coord_t bx_q;
	blp_pkg::coord_t by_q;
	blp_pkg::setup_t geom;
	blp_pkg::setup_t geom_q;
	blp_pkg::err_t inc_axial_q;
	blp_pkg::err_t inc_diag_q;
	blp_pkg::err_t err_q;
	blp_pkg::err_t err_next;
	blp_pkg::err_op_t err_op;
	blp_pkg::coord_t maj_q;
	blp_pkg::coord_t mn_q;

	logic req_take;
	logic load;
	logic at_end;
	logic err_pos;

	// Handshake and step conditions.
	assign req.ready = (state_q == ST_IDLE);
	assign req_take = req.valid && (state_q == ST_IDLE);
	assign load = (state_q == ST_RUN) && (!pt_valid_q || pt.ready);
	assign at_end = (maj_q == geom_q.maj_end);
	assign err_pos = (err_q > blp_pkg::err_t'(0));

	// Shared adder operation for this cycle.
	always_comb begin
		if (state_q == ST_INIT) begin
			err_op = blp_pkg::OP_INIT;
		end else if (err_pos) begin
			err_op = blp_pkg::OP_DIAG;
		end else begin
			err_op = blp_pkg::OP_AXIAL;
		end
	end

	blp_setup u_setup (
		.ax(ax_q),
		.ay(ay_q),
		.bx(bx_q),
		.by(by_q),
		.geom(geom)
	);

	blp_err_unit u_err (
		.op(err_op),
		.err(err_q),
		.inc_axial(inc_axial_q),
		.inc_diag(inc_diag_q),
		.dmaj(geom_q.dmaj),
		.err_next(err_next)
	);

	// Sequencer and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pt_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (load && at_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				pt_valid_q <= 1'b1;
			end else if (pt.ready) begin
				pt_valid_q <= 1'b0;
			end
		end
	end

	// Endpoint capture with saturation to the grid.
	always_ff @(posedge clk) begin
		if (req_take) begin
			ax_q <= (req.start_x > MAX_COORD) ? MAX_COORD : req.start_x;
			ay_q <= (req.start_y > MAX_COORD) ? MAX_COORD : req.start_y;
			bx_q <= (req.end_x > MAX_COORD) ? MAX_COORD : req.end_x;
			by_q <= (req.end_y > MAX_COORD) ? MAX_COORD : req.end_y;
		end
	end

	// Line geometry and the two error increments.
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			geom_q <= geom;
			maj_q <= geom.maj0;
			mn_q <= geom.min0;
			inc_axial_q <= blp_pkg::err_t'({geom.dmin, 1'b0});
			inc_diag_q <= blp_pkg::err_t'({geom.dmin, 1'b0})
				- blp_pkg::err_t'({geom.dmaj, 1'b0});
		end else if (load && !at_end) begin
			maj_q <= maj_q + blp_pkg::coord_t'(1);
			if (err_pos) begin
				mn_q <= geom_q.minor_neg ? mn_q - blp_pkg::coord_t'(1)
					: mn_q + blp_pkg::coord_t'(1);
			end
		end
	end

	// Error term: initialized once, then updated after every emitted cell but the last.
	always_ff @(posedge clk) begin
		if ((state_q == ST_INIT) || (load && !at_end)) begin
			err_q <= err_next;
		end
	end

	// Output register for the current cell.
	always_ff @(posedge clk) begin
		if (load) begin
			pt_x_q <= geom_q.along_y ? mn_q : maj_q;
			pt_y_q <= geom_q.along_y ? maj_q : mn_q;
			pt_last_q <= at_end;
		end
	end

	assign pt.valid = pt_valid_q;
	assign pt.point_x = pt_x_q;
	assign pt.point_y = pt_y_q;
	assign pt.last_point = pt_last_q;

	// A taken request always moves the sequencer into setup.
	a_take_setup: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_SETUP)
		else $error("request taken without entering setup");

	// The major coordinate never runs past its end value.
	a_maj_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> maj_q <= geom_q.maj_end)
		else $error("major coordinate past line end");

	// The error term stays between the diagonal and axial increments.
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (err_q <= inc_axial_q) && (err_q >= inc_diag_q))
		else $error("error term out of range");

	// Nothing new is loaded while a cell is stalled at the output.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid_q && !pt.ready |-> !load)
		else $error("output overwritten while stalled");

endmodule

FILE: hdl/blp_setup.sv
// Setup logic: picks the major axis, orders the endpoints and forms the spans.
// Depends on blp_pkg for coord_t and setup_t.
module blp_setup (
	input blp_pkg::coord_t ax,
	input blp_pkg::coord_t ay,
	input blp_pkg::coord_t bx,
	input blp_pkg::coord_t by,
	output blp_pkg::setup_t geom
);

	blp_pkg::coord_t adx;
	blp_pkg::coord_t ady;
	blp_pkg::coord_t min1;

	// Absolute spans on both axes.
	assign adx = (ax > bx) ? ax - bx : bx - ax;
	assign ady = (ay > by) ? ay - by : by - ay;

	// The line steps along y unless the vertical span is strictly smaller.
	// Endpoints are ordered so that the major coordinate increases.
	always_comb begin
		geom.along_y = !(ady < adx);
		if (!geom.along_y) begin
			geom.dmaj = adx;
			geom.dmin = ady;
			if (ax > bx) begin
				geom.maj0 = bx;
				geom.min0 = by;
				geom.maj_end = ax;
				min1 = ay;
			end else begin
				geom.maj0 = ax;
				geom.min0 = ay;
				geom.maj_end = bx;
				min1 = by;
			end
		end else begin
			geom.dmaj = ady;
			geom.dmin = adx;
			if (ay > by) begin
				geom.maj0 = by;
				geom.min0 = bx;
				geom.maj_end = ay;
				min1 = ax;
			end else begin
				geom.maj0 = ay;
				geom.min0 = ax;
				geom.maj_end = by;
				min1 = bx;
			end
		end
		geom.minor_neg = min1 < geom.min0;
	end

endmodule

FILE: hdl/blp_err_unit.sv
// Shared error-term adder: forms the initial error and applies every per-cell update.
// Depends on blp_pkg for err_t, coord_t and the operation codes.
module blp_err_unit (
	input blp_pkg::err_op_t op,
	input blp_pkg::err_t err,
	input blp_pkg::err_t inc_axial,
	input blp_pkg::err_t inc_diag,
	input blp_pkg::coord_t dmaj,
	output blp_pkg::err_t err_next
);

	blp_pkg::err_t opa;
	blp_pkg::err_t opb;

	// Operand selection for the single adder.
	always_comb begin
		case (op)
			blp_pkg::OP_AXIAL: begin
				opa = err;
				opb = inc_axial;
			end
			blp_pkg::OP_DIAG: begin
				opa = err;
				opb = inc_diag;
			end
			default: begin
				// Initial error is twice the minor span minus the major span.
				opa = inc_axial;
				opb = -blp_pkg::err_t'({1'b0, dmaj});
			end
		endcase
	end

	assign err_next = opa + opb;

endmodule
